// ===== sv/lrb_pkg.sv =====
// Shared types and constants of the banked line rasterizer.
// Holds the channel payload structs, the item kind codes and default sizes.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package lrb_pkg;

  // Default sizes handed to the top level parameters.
  localparam int COORD_BITS_DEF       = 11;
  localparam int BANK_OFFSET_BITS_DEF = 16;

  // Fixed widths of the channel fields and of the stride register.
  localparam int FIELD_COORD_W = 11;
  localparam int COLOR_W       = 8;
  localparam int BANK_W        = 7;
  localparam int OFFSET_W      = 16;
  localparam int STRIDE_W      = 12;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd800;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [FIELD_COORD_W-1:0] x_start;
    logic [FIELD_COORD_W-1:0] y_start;
    logic [FIELD_COORD_W-1:0] x_end;
    logic [FIELD_COORD_W-1:0] y_end;
    logic [COLOR_W-1:0]       color;
  } lrb_in_t;

  typedef struct packed {
    logic [FIELD_COORD_W-1:0] pixel_x;
    logic [FIELD_COORD_W-1:0] pixel_y;
    logic [BANK_W-1:0]        bank;
    logic [OFFSET_W-1:0]      offset;
    logic                     bank_changed;
    logic [COLOR_W-1:0]       pixel_color;
    logic                     last;
  } lrb_out_t;

endpackage

// ===== sv/lrb_stream_if.sv =====
// Valid/ready stream interfaces for the command and pixel channels.
// Depends on lrb_pkg for the payload structs.
`timescale 1ns / 1ps

interface lrb_in_if;
  logic            valid;
  logic            ready;
  lrb_pkg::lrb_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrb_out_if;
  logic             valid;
  logic             ready;
  lrb_pkg::lrb_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/line_rasterizer_banked.sv =====
// Top level of the banked Bresenham line rasterizer.
// Depends on lrb_pkg and on the stream interfaces in lrb_stream_if.sv.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_chan   sink       valid / ready      kind, x_start, y_start, x_end, y_end, color
// out_chan  source     valid / ready      pixel_x, pixel_y, bank, offset,
//                                         bank_changed, pixel_color, last
// cfg       write      cfg_we             cfg_wdata = line_stride
//
// One command is taken per cycle while in_chan.ready is high. A step that emits a pixel
// passes the middle stage, which registers the row times stride multiply, and then the
// output register, which takes the add of the column, the bank split and the bank compare.
// The Bresenham state advances in the cycle of the transfer, so steps run back to back.
// Reset is synchronous and active low; it clears the line state and loads stride 800.
// A stalled output holds its pixel; input is still taken while the middle stage is free.

module line_rasterizer_banked #(
  parameter int COORD_BITS       = lrb_pkg::COORD_BITS_DEF,
  parameter int BANK_OFFSET_BITS = lrb_pkg::BANK_OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lrb_in_if.sink                        in_chan,
  lrb_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [lrb_pkg::STRIDE_W-1:0]  cfg_wdata
);

  localparam int ERR_W  = COORD_BITS + 2;
  localparam int PROD_W = COORD_BITS + lrb_pkg::STRIDE_W;
  localparam int ADDR_W = PROD_W + 1;
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << BANK_OFFSET_BITS) - 64'd1);

  // Line state.
  logic [lrb_pkg::STRIDE_W-1:0] stride_r,  stride_nxt;
  logic [COORD_BITS-1:0]        cur_x_r,   cur_x_nxt;
  logic [COORD_BITS-1:0]        cur_y_r,   cur_y_nxt;
  logic [COORD_BITS-1:0]        end_x_r,   end_x_nxt;
  logic [COORD_BITS-1:0]        end_y_r,   end_y_nxt;
  logic [COORD_BITS-1:0]        delta_x_r, delta_x_nxt;
  logic [COORD_BITS-1:0]        delta_y_r, delta_y_nxt;
  logic                         x_neg_r,   x_neg_nxt;
  logic                         y_neg_r,   y_neg_nxt;
  logic signed [ERR_W-1:0]      err_r,     err_nxt;
  logic [lrb_pkg::COLOR_W-1:0]  color_r,   color_nxt;
  logic                         active_r,  active_nxt;
  logic [lrb_pkg::BANK_W-1:0]   last_bank_r, last_bank_nxt;

  // Middle stage: the emitted point and its row product.
  logic                         s1_valid_r, s1_valid_nxt;
  logic [COORD_BITS-1:0]        s1_x_r,     s1_x_nxt;
  logic [COORD_BITS-1:0]        s1_y_r,     s1_y_nxt;
  logic [PROD_W-1:0]            s1_prod_r,  s1_prod_nxt;
  logic [lrb_pkg::COLOR_W-1:0]  s1_color_r, s1_color_nxt;
  logic                         s1_last_r,  s1_last_nxt;

  // Output stage.
  logic                         out_valid_r, out_valid_nxt;
  lrb_pkg::lrb_out_t            out_data_r,  out_data_nxt;

  logic                         out_adv;
  logic                         in_xfer;
  logic                         is_step;
  logic                         emit;
  logic                         done;

  // Load decode.
  logic [COORD_BITS-1:0]        ld_x0, ld_y0, ld_x1, ld_y1;
  logic [COORD_BITS-1:0]        ld_dx, ld_dy;
  logic signed [ERR_W-1:0]      ld_err;

  // Bresenham step.
  logic signed [ERR_W-1:0]      dx_s, dy_s;
  logic                         step_x, step_y;

  // Address split.
  logic [ADDR_W-1:0]            addr;
  logic [ADDR_W-1:0]            addr_shift;
  logic [ADDR_W-1:0]            addr_low;
  logic [lrb_pkg::BANK_W-1:0]   bank;

  // The output register takes a new pixel whenever it is empty or being drained;
  // the middle stage is free under the same condition or when it is empty.
  assign out_adv       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || out_adv;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign is_step       = (in_chan.data.kind == lrb_pkg::KIND_STEP);
  assign emit          = in_xfer && is_step && active_r;
  assign done          = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);

  assign ld_x0  = COORD_BITS'(in_chan.data.x_start);
  assign ld_y0  = COORD_BITS'(in_chan.data.y_start);
  assign ld_x1  = COORD_BITS'(in_chan.data.x_end);
  assign ld_y1  = COORD_BITS'(in_chan.data.y_end);
  assign ld_dx  = (ld_x1 > ld_x0) ? (ld_x1 - ld_x0) : (ld_x0 - ld_x1);
  assign ld_dy  = (ld_y1 > ld_y0) ? (ld_y1 - ld_y0) : (ld_y0 - ld_y1);
  assign ld_err = (ld_dx > ld_dy) ? $signed({2'b00, ld_dx >> 1})
                                  : -$signed({2'b00, ld_dy >> 1});

  // The classic error test uses the error before either update of this step.
  assign dx_s   = $signed({2'b00, delta_x_r});
  assign dy_s   = $signed({2'b00, delta_y_r});
  assign step_x = err_r > -dx_s;
  assign step_y = err_r < dy_s;

  always_comb begin
    stride_nxt    = cfg_we ? cfg_wdata : stride_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    end_x_nxt     = end_x_r;
    end_y_nxt     = end_y_r;
    delta_x_nxt   = delta_x_r;
    delta_y_nxt   = delta_y_r;
    x_neg_nxt     = x_neg_r;
    y_neg_nxt     = y_neg_r;
    err_nxt       = err_r;
    color_nxt     = color_r;
    active_nxt    = active_r;

    if (in_xfer && !is_step) begin
      // A load replaces any line in progress at once.
      cur_x_nxt   = ld_x0;
      cur_y_nxt   = ld_y0;
      end_x_nxt   = ld_x1;
      end_y_nxt   = ld_y1;
      delta_x_nxt = ld_dx;
      delta_y_nxt = ld_dy;
      x_neg_nxt   = !(ld_x0 < ld_x1);
      y_neg_nxt   = !(ld_y0 < ld_y1);
      err_nxt     = ld_err;
      color_nxt   = in_chan.data.color;
      active_nxt  = 1'b1;
    end else if (emit) begin
      if (done) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = err_r - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
        if (step_x) begin
          cur_x_nxt = x_neg_r ? (cur_x_r - COORD_BITS'(1)) : (cur_x_r + COORD_BITS'(1));
        end
        if (step_y) begin
          cur_y_nxt = y_neg_r ? (cur_y_r - COORD_BITS'(1)) : (cur_y_r + COORD_BITS'(1));
        end
      end
    end
  end

  // Middle stage: the point as it stood before the update, with its row product.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_x_nxt     = s1_x_r;
    s1_y_nxt     = s1_y_r;
    s1_prod_nxt  = s1_prod_r;
    s1_color_nxt = s1_color_r;
    s1_last_nxt  = s1_last_r;
    if (emit) begin
      s1_valid_nxt = 1'b1;
      s1_x_nxt     = cur_x_r;
      s1_y_nxt     = cur_y_r;
      s1_prod_nxt  = {{lrb_pkg::STRIDE_W{1'b0}}, cur_y_r} * {{COORD_BITS{1'b0}}, stride_r};
      s1_color_nxt = color_r;
      s1_last_nxt  = done;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Output stage: finish the linear address and split it into bank and offset.
  assign addr       = {1'b0, s1_prod_r} + {{(ADDR_W - COORD_BITS){1'b0}}, s1_x_r};
  assign addr_shift = addr >> BANK_OFFSET_BITS;
  assign addr_low   = addr & OFF_MASK;
  assign bank       = addr_shift[lrb_pkg::BANK_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    last_bank_nxt = last_bank_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_data_nxt.pixel_x      = lrb_pkg::FIELD_COORD_W'(s1_x_r);
        out_data_nxt.pixel_y      = lrb_pkg::FIELD_COORD_W'(s1_y_r);
        out_data_nxt.bank         = bank;
        out_data_nxt.offset       = addr_low[lrb_pkg::OFFSET_W-1:0];
        out_data_nxt.bank_changed = (bank != last_bank_r);
        out_data_nxt.pixel_color  = s1_color_r;
        out_data_nxt.last         = s1_last_r;
        // Pixels leave this stage in order, so the bank kept here is always
        // the bank of the pixel emitted just before.
        last_bank_nxt             = bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r    <= lrb_pkg::STRIDE_RESET;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      delta_x_r   <= '0;
      delta_y_r   <= '0;
      x_neg_r     <= 1'b0;
      y_neg_r     <= 1'b0;
      err_r       <= '0;
      color_r     <= '0;
      active_r    <= 1'b0;
      last_bank_r <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stride_r    <= stride_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      end_x_r     <= end_x_nxt;
      end_y_r     <= end_y_nxt;
      delta_x_r   <= delta_x_nxt;
      delta_y_r   <= delta_y_nxt;
      x_neg_r     <= x_neg_nxt;
      y_neg_r     <= y_neg_nxt;
      err_r       <= err_nxt;
      color_r     <= color_nxt;
      active_r    <= active_nxt;
      last_bank_r <= last_bank_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    s1_x_r     <= s1_x_nxt;
    s1_y_r     <= s1_y_nxt;
    s1_prod_r  <= s1_prod_nxt;
    s1_color_r <= s1_color_nxt;
    s1_last_r  <= s1_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // A pixel in the middle stage holds while the output register stays full.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_x_r) && $stable(s1_prod_r)))
    else $error("middle stage changed while the output was stalled");

  // A step taken with no line in progress never produces a pixel.
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && is_step && !active_r) |=> !s1_valid_r)
    else $error("step without an active line produced a pixel");

  // The final pixel of a line ends it.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && done) |=> (!active_r && s1_valid_r && s1_last_r))
    else $error("final pixel did not end the line");

endmodule

// ===== dv/line_rasterizer_banked_test.sv =====
// Self-checking testbench for the banked Bresenham line rasterizer.
// Depends on lrb_pkg, lrb_stream_if.sv and line_rasterizer_banked.sv.
`timescale 1ns / 1ps

module line_rasterizer_banked_test;

  // Run sizing. The block answers a step through its middle stage and output register,
  // so the DRAIN_CYCLES wait after the last pixel is enough for the pipeline to run dry.
  localparam int PHASE_ITEMS = 365;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_SHOWN = 10;
  localparam int COORD_MAX = (1 << lrb_pkg::FIELD_COORD_W) - 1;
  localparam int BOFF = lrb_pkg::BANK_OFFSET_BITS_DEF;

  // How a row of the directed table is judged: by the line tracker, by a typed-in
  // pixel, or as a command that must not produce a pixel at all.
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_VALUE = 2'd1,
    CHK_NONE  = 2'd2
  } chk_mode_t;

  // Patterns of the pixel receiver.
  typedef enum logic [1:0] {
    SINK_OPEN     = 2'd0,
    SINK_COIN     = 2'd1,
    SINK_PERIODIC = 2'd2
  } sink_mode_t;

  typedef struct packed {
    lrb_pkg::lrb_in_t  item;
    chk_mode_t         mode;
    lrb_pkg::lrb_out_t want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [lrb_pkg::STRIDE_W-1:0] cfg_wdata;

  lrb_in_if  cmd_if ();
  lrb_out_if pix_if ();

  line_rasterizer_banked u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_if),
    .out_chan (pix_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Line tracker: its own copy of the engine state and of the stride register.
  logic [lrb_pkg::FIELD_COORD_W-1:0] ln_x, ln_y, ln_end_x, ln_end_y;
  logic [lrb_pkg::FIELD_COORD_W-1:0] ln_dx, ln_dy;
  bit                                ln_xneg, ln_yneg;
  int                                ln_err;
  logic [lrb_pkg::COLOR_W-1:0]       ln_color;
  bit                                ln_busy;
  logic [lrb_pkg::BANK_W-1:0]        ln_prev_bank;
  logic [lrb_pkg::STRIDE_W-1:0]      ln_stride;

  // Pixels still owed by the block, oldest first, and the judging mode of every
  // command that has been offered but not yet counted as a transfer.
  lrb_pkg::lrb_out_t pixel_expect_q[$];
  chk_mode_t         row_mode_q[$];
  lrb_pkg::lrb_out_t row_want_q[$];
  dir_row_t          dir_rows[$];

  int fail_count;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the tracked line by one command. Returns 1 when a pixel comes out,
  // and then fills in that pixel.
  function automatic bit rasterize_item(input lrb_pkg::lrb_in_t it,
                                        output lrb_pkg::lrb_out_t px);
    logic [31:0] lin;
    int          e2;
    bit          done;
    px = '0;
    if (it.kind == lrb_pkg::KIND_LOAD) begin
      ln_x     = it.x_start;
      ln_y     = it.y_start;
      ln_end_x = it.x_end;
      ln_end_y = it.y_end;
      ln_dx    = (it.x_end > it.x_start) ? it.x_end - it.x_start : it.x_start - it.x_end;
      ln_dy    = (it.y_end > it.y_start) ? it.y_end - it.y_start : it.y_start - it.y_end;
      ln_xneg  = !(it.x_start < it.x_end);
      ln_yneg  = !(it.y_start < it.y_end);
      // The error term starts at half of the major delta, negative when y leads or ties.
      if (ln_dx > ln_dy) ln_err = int'(ln_dx >> 1);
      else ln_err = 0 - int'(ln_dy >> 1);
      ln_color = it.color;
      ln_busy  = 1'b1;
      return 1'b0;
    end
    // A step with no line in progress leaves everything untouched.
    if (!ln_busy) return 1'b0;
    lin = 32'(ln_y) * 32'(ln_stride) + 32'(ln_x);
    px.pixel_x      = ln_x;
    px.pixel_y      = ln_y;
    px.bank         = lin[BOFF +: lrb_pkg::BANK_W];
    px.offset       = lin[lrb_pkg::OFFSET_W-1:0];
    px.bank_changed = (px.bank != ln_prev_bank);
    px.pixel_color  = ln_color;
    done            = (ln_x == ln_end_x) && (ln_y == ln_end_y);
    px.last         = done;
    ln_prev_bank    = px.bank;
    if (done) begin
      ln_busy = 1'b0;
      return 1'b1;
    end
    e2 = ln_err;
    if (e2 > -int'(ln_dx)) begin
      ln_err = ln_err - int'(ln_dy);
      ln_x   = ln_xneg ? ln_x - lrb_pkg::FIELD_COORD_W'(1) : ln_x + lrb_pkg::FIELD_COORD_W'(1);
    end
    if (e2 < int'(ln_dy)) begin
      ln_err = ln_err + int'(ln_dx);
      ln_y   = ln_yneg ? ln_y - lrb_pkg::FIELD_COORD_W'(1) : ln_y + lrb_pkg::FIELD_COORD_W'(1);
    end
    return 1'b1;
  endfunction

  function automatic lrb_pkg::lrb_in_t cmd(lrb_pkg::kind_t k, int x0, int y0, int x1, int y1,
                                           int col);
    lrb_pkg::lrb_in_t it;
    it.kind    = k;
    it.x_start = lrb_pkg::FIELD_COORD_W'(x0);
    it.y_start = lrb_pkg::FIELD_COORD_W'(y0);
    it.x_end   = lrb_pkg::FIELD_COORD_W'(x1);
    it.y_end   = lrb_pkg::FIELD_COORD_W'(y1);
    it.color   = lrb_pkg::COLOR_W'(col);
    return it;
  endfunction

  function automatic lrb_pkg::lrb_out_t pix(int x, int y, int bnk, int off, bit bc, int col,
                                            bit lst);
    lrb_pkg::lrb_out_t p;
    p.pixel_x      = lrb_pkg::FIELD_COORD_W'(x);
    p.pixel_y      = lrb_pkg::FIELD_COORD_W'(y);
    p.bank         = lrb_pkg::BANK_W'(bnk);
    p.offset       = lrb_pkg::OFFSET_W'(off);
    p.bank_changed = bc;
    p.pixel_color  = lrb_pkg::COLOR_W'(col);
    p.last         = lst;
    return p;
  endfunction

  function automatic lrb_pkg::lrb_in_t rand_cmd(lrb_pkg::kind_t k);
    return cmd(k, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
               $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
               $urandom_range(0, 255));
  endfunction

  // Coordinates lean on the edges of the field so that both extremes show up often.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 24) return COORD_MAX;
    return $urandom_range(0, COORD_MAX);
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  function automatic void add_row(lrb_pkg::lrb_in_t it, chk_mode_t m, lrb_pkg::lrb_out_t w);
    dir_row_t r;
    r.item = it;
    r.mode = m;
    r.want = w;
    dir_rows.push_back(r);
  endfunction

  function automatic void compare_pixel(lrb_pkg::lrb_out_t want, lrb_pkg::lrb_out_t got);
    bit bad;
    bad = (got.pixel_x !== want.pixel_x) || (got.pixel_y !== want.pixel_y) ||
          (got.bank !== want.bank) || (got.offset !== want.offset) ||
          (got.bank_changed !== want.bank_changed) ||
          (got.pixel_color !== want.pixel_color) || (got.last !== want.last);
    if (bad) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN) begin
        $display("pixel mismatch: exp x=%0d y=%0d bank=%0d off=%0d chg=%0b col=%0h last=%0b",
                 want.pixel_x, want.pixel_y, want.bank, want.offset, want.bank_changed,
                 want.pixel_color, want.last);
        $display("                got x=%0d y=%0d bank=%0d off=%0d chg=%0b col=%0h last=%0b",
                 got.pixel_x, got.pixel_y, got.bank, got.offset, got.bank_changed,
                 got.pixel_color, got.last);
      end
    end
  endfunction

  // Both channels are observed at the rising edge. A command transfer first
  // advances the tracker; a pixel transfer is then matched against the oldest
  // pixel still owed. A step's pixel passes the middle stage and the output register,
  // so a command can never owe the pixel that moves in the same cycle.
  always @(posedge clk) begin : watch_channels
    lrb_pkg::lrb_out_t p;
    lrb_pkg::lrb_out_t want;
    bit                got;
    chk_mode_t         mode;
    if (rst_n === 1'b1) begin
      if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
        got  = rasterize_item(cmd_if.data, p);
        mode = row_mode_q.pop_front();
        want = row_want_q.pop_front();
        case (mode)
          CHK_MODEL: begin
            if (got) pixel_expect_q.push_back(p);
          end
          CHK_VALUE: begin
            // The typed pixel is what the block is held to; the tracker must agree.
            if (!got) begin
              fail_count++;
              if (fail_count <= MAX_SHOWN) $display("tracker gives no pixel for a typed row");
            end else begin
              compare_pixel(want, p);
            end
            pixel_expect_q.push_back(want);
          end
          default: begin
            if (got) begin
              fail_count++;
              if (fail_count <= MAX_SHOWN) $display("tracker gives a pixel where none is due");
            end
          end
        endcase
      end
      if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
        if (pixel_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("unexpected pixel x=%0d y=%0d", pix_if.data.pixel_x, pix_if.data.pixel_y);
        end else begin
          want = pixel_expect_q.pop_front();
          compare_pixel(want, pix_if.data);
        end
      end
    end
  end

  // The pixel receiver switches between patterns after a random stretch: always
  // ready, a coin toss each cycle, or a stall once in every period of random length.
  initial begin : sink_pacing
    sink_mode_t mode;
    int         left;
    int         period;
    int         phase;
    mode   = SINK_OPEN;
    left   = 0;
    period = 2;
    phase  = 0;
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode   = sink_mode_t'($urandom_range(0, 2));
        left   = $urandom_range(20, 200);
        period = $urandom_range(2, 6);
      end
      left--;
      phase++;
      case (mode)
        SINK_OPEN: pix_if.ready <= 1'b1;
        SINK_COIN: pix_if.ready <= ($urandom_range(0, 1) == 1);
        default:   pix_if.ready <= ((phase % period) != 0);
      endcase
    end
  end

  // Offers one command from a falling edge and returns at the falling edge after
  // its transfer. Commands come in bursts; at the end of a burst valid drops for a
  // random gap. A gap of zero keeps valid high straight into the next command.
  task automatic send_item(input lrb_pkg::lrb_in_t it, input chk_mode_t mode,
                           input lrb_pkg::lrb_out_t want);
    int gap;
    row_mode_q.push_back(mode);
    row_want_q.push_back(want);
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Holds the command channel quiet until every owed pixel has come out, then lets
  // the pipeline run dry. The stride is only rewritten after this.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_stride(input logic [lrb_pkg::STRIDE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    ln_stride = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Directed rows run at the reset stride of 800. Typed pixels follow directly
  // from it: the far corner sits at 2047 * 800 + 2047, which is bank 25,
  // offset 1247, and it is the first pixel to leave bank 0.
  task automatic run_directed();
    lrb_pkg::lrb_out_t nil;
    nil = '0;
    // A step before any line has been loaded gives nothing.
    add_row(cmd(lrb_pkg::KIND_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 255),
            CHK_NONE, nil);
    // Single-point line at the origin: one pixel, flagged as the last one.
    add_row(cmd(lrb_pkg::KIND_LOAD, 0, 0, 0, 0, 'hFF), CHK_NONE, nil);
    add_row(cmd(lrb_pkg::KIND_STEP, 0, 0, 0, 0, 0), CHK_VALUE,
            pix(0, 0, 0, 0, 1'b0, 'hFF, 1'b1));
    add_row(cmd(lrb_pkg::KIND_STEP, 0, 0, 0, 0, 0), CHK_NONE, nil);
    // Single-point line at the far corner.
    add_row(cmd(lrb_pkg::KIND_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0),
            CHK_NONE, nil);
    add_row(cmd(lrb_pkg::KIND_STEP, 0, 0, 0, 0, 'hFF), CHK_VALUE,
            pix(COORD_MAX, COORD_MAX, 25, 1247, 1'b1, 0, 1'b1));
    // Shallow line, walked to its end and then stepped once more while idle.
    add_row(cmd(lrb_pkg::KIND_LOAD, 0, 0, 3, 1, 'h5A), CHK_NONE, nil);
    repeat (4) add_row(cmd(lrb_pkg::KIND_STEP, 1, 2, 3, 4, 'h11), CHK_MODEL, nil);
    add_row(cmd(lrb_pkg::KIND_STEP, 0, 0, 0, 0, 0), CHK_NONE, nil);
    // Steep line heading toward smaller x, left unfinished.
    add_row(cmd(lrb_pkg::KIND_LOAD, 10, 10, 7, 14, 'hA5), CHK_NONE, nil);
    repeat (3) add_row(cmd(lrb_pkg::KIND_STEP, COORD_MAX, 0, COORD_MAX, 0, 'h00),
                       CHK_MODEL, nil);
    // A new load replaces the line in progress at once.
    add_row(cmd(lrb_pkg::KIND_LOAD, COORD_MAX, 0, 0, COORD_MAX, 'h3C), CHK_NONE, nil);
    repeat (3) add_row(cmd(lrb_pkg::KIND_STEP, 0, COORD_MAX, 0, COORD_MAX, 'hC3),
                       CHK_MODEL, nil);
    // Vertical line going up, then a horizontal one going left.
    add_row(cmd(lrb_pkg::KIND_LOAD, 5, 9, 5, 5, 'h81), CHK_NONE, nil);
    repeat (2) add_row(cmd(lrb_pkg::KIND_STEP, 0, 0, 0, 0, 0), CHK_MODEL, nil);
    add_row(cmd(lrb_pkg::KIND_LOAD, COORD_MAX, 100, 0, 100, 'h7E), CHK_NONE, nil);
    add_row(cmd(lrb_pkg::KIND_STEP, 0, 0, 0, 0, 0), CHK_MODEL, nil);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].mode, dir_rows[i].want);
  endtask

  // Random part. Most of it is complete lines with random content; the rest are
  // lines cut short by the next load, steps past the end of a line, and commands
  // with every field random. Steps that only hit an idle engine are not counted.
  task automatic run_random(input int quota);
    int                count;
    int                shape;
    int                n;
    int                steps;
    int                extra;
    int                x0, y0, x1, y1;
    int                adx, ady;
    bit                broken;
    lrb_pkg::lrb_in_t  it;
    lrb_pkg::lrb_out_t nil;
    nil   = '0;
    count = 0;
    while (count < quota) begin
      if ($urandom_range(0, 99) < 10) begin
        it = rand_cmd(lrb_pkg::kind_t'($urandom_range(0, 1)));
        send_item(it, CHK_MODEL, nil);
        if (it.kind == lrb_pkg::KIND_LOAD) count++;
      end else begin
        x0     = pick_coord();
        y0     = pick_coord();
        x1     = x0;
        y1     = y0;
        broken = 1'b0;
        extra  = 0;
        shape  = $urandom_range(0, 99);
        if (shape < 65) begin
          x1 = clamp_coord(x0 + $urandom_range(0, 40) - 20);
          y1 = clamp_coord(y0 + $urandom_range(0, 40) - 20);
        end else if (shape < 80) begin
          // Axis-aligned lines and single points.
          case ($urandom_range(0, 2))
            0: y1 = clamp_coord(y0 + $urandom_range(0, 60) - 30);
            1: x1 = clamp_coord(x0 + $urandom_range(0, 60) - 30);
            default: ;
          endcase
        end else begin
          x1     = pick_coord();
          y1     = pick_coord();
          broken = 1'b1;
        end
        adx   = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady   = (y1 > y0) ? y1 - y0 : y0 - y1;
        n     = ((adx > ady) ? adx : ady) + 1;
        steps = n;
        if (broken || $urandom_range(0, 9) == 0)
          steps = $urandom_range(0, (n < 48) ? n - 1 : 47);
        else if ($urandom_range(0, 3) == 0)
          extra = $urandom_range(1, 3);
        it = rand_cmd(lrb_pkg::KIND_LOAD);
        it.x_start = lrb_pkg::FIELD_COORD_W'(x0);
        it.y_start = lrb_pkg::FIELD_COORD_W'(y0);
        it.x_end   = lrb_pkg::FIELD_COORD_W'(x1);
        it.y_end   = lrb_pkg::FIELD_COORD_W'(y1);
        send_item(it, CHK_MODEL, nil);
        count++;
        repeat (steps) begin
          send_item(rand_cmd(lrb_pkg::KIND_STEP), CHK_MODEL, nil);
          count++;
        end
        repeat (extra) send_item(rand_cmd(lrb_pkg::KIND_STEP), CHK_MODEL, nil);
      end
    end
  endtask

  // Any run that is still going after this many cycles has hung somewhere.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : main_flow
    logic [lrb_pkg::STRIDE_W-1:0] strides[5];
    rst_n        = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    fail_count   = 0;
    burst_left   = 0;
    ln_x         = '0;
    ln_y         = '0;
    ln_end_x     = '0;
    ln_end_y     = '0;
    ln_dx        = '0;
    ln_dy        = '0;
    ln_xneg      = 1'b0;
    ln_yneg      = 1'b0;
    ln_err       = 0;
    ln_color     = '0;
    ln_busy      = 1'b0;
    ln_prev_bank = '0;
    ln_stride    = lrb_pkg::STRIDE_RESET;
    // Stride of one and the widest stride first, then zero (the address is just
    // the column), one random value, and finally back to the reset value.
    strides[0] = 12'd1;
    strides[1] = 12'd4095;
    strides[2] = 12'd0;
    strides[3] = lrb_pkg::STRIDE_W'($urandom_range(2, 4094));
    strides[4] = lrb_pkg::STRIDE_RESET;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    settle();
    foreach (strides[i]) begin
      write_stride(strides[i]);
      run_random(PHASE_ITEMS);
      settle();
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
